// ===== rtl/core/bkv_pkg.sv =====
// Package for the knot vector builder: widths, defaults, register indexes, reset values, types.
// No dependencies; imported by bkv_len and the top module.
package bkv_pkg;

  localparam int unsigned COORD_W   = 32;   // Q15.16 coordinate
  localparam int unsigned LEN_W     = 48;   // running length
  localparam int unsigned ROOT_W    = 34;   // segment length from sqrt
  localparam int unsigned RAD_W     = 68;   // sum of three squares
  localparam int unsigned N_W       = 6;    // last_control_index
  localparam int unsigned P_W       = 3;    // degree
  localparam int unsigned KNOT_W    = 17;   // knot_value field
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 6;
  localparam int unsigned BIN_DEPTH = 56;

  localparam int unsigned MAX_POINTS_DEF = 1024;
  localparam int unsigned MAX_KNOTS_DEF  = 64;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LAST_CTRL = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DEGREE    = CFG_IDX_W'(1);

  localparam logic [N_W-1:0] LAST_CTRL_RST = N_W'(3);
  localparam logic [P_W-1:0] DEGREE_RST    = P_W'(3);

  typedef logic [2:0][COORD_W-1:0] point_t;

  typedef enum logic [2:0] {
    LEN_IDLE,
    LEN_DIFF,
    LEN_MUL,
    LEN_ACC,
    LEN_ROOT
  } len_state_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LEN,
    ST_STORE,
    ST_CHECK,
    ST_BEND,
    ST_BEND_W,
    ST_RD,
    ST_U,
    ST_U_W,
    ST_MEAN,
    ST_MEAN_W,
    ST_NEXT_BIN,
    ST_EMIT,
    ST_KRD,
    ST_KACC,
    ST_KDIV,
    ST_PUSH
  } bkv_state_e;

endpackage

// ===== rtl/core/bkv_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module bkv_div #(
  parameter int unsigned NUM_W = 64,
  parameter int unsigned DEN_W = 48
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] sh_q;
  logic [DEN_W:0]   rem_q;
  logic [DEN_W-1:0] den_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial = {rem_q[DEN_W-1:0], sh_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? (trial - {1'b0, den_q}) : trial;
      sh_q  <= {sh_q[NUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = sh_q;

endmodule

// ===== rtl/core/bkv_len.sv =====
// Segment length unit: three squared deltas on one multiplier, then a
// two-bits-per-cycle integer square root. Depends on bkv_pkg.
module bkv_len (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  bkv_pkg::point_t           cur_i,
  input  bkv_pkg::point_t           prev_i,
  output logic                      done_o,
  output logic [bkv_pkg::ROOT_W-1:0] len_o
);
  import bkv_pkg::*;

  localparam int unsigned REM_W = ROOT_W + 3;

  len_state_e          state_q, state_d;
  logic [1:0]          axis_q, axis_d;
  logic [5:0]          step_q, step_d;
  logic                done_q, done_d;
  logic [COORD_W-1:0]  d_q;
  logic [2*COORD_W-1:0] prod_q;
  logic [RAD_W-1:0]    acc_q;
  logic [REM_W-1:0]    rem_q;
  logic [ROOT_W-1:0]   root_q;

  logic [COORD_W:0]    diff;
  logic [REM_W-1:0]    rem_n, trial;
  logic                ge;

  assign diff  = {cur_i[axis_q][COORD_W-1], cur_i[axis_q]} -
                 {prev_i[axis_q][COORD_W-1], prev_i[axis_q]};
  assign rem_n = {rem_q[REM_W-3:0], acc_q[RAD_W-1 -: 2]};
  assign trial = REM_W'({root_q, 2'b01});
  assign ge    = rem_n >= trial;

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    step_d  = step_q;
    done_d  = 1'b0;
    case (state_q)
      LEN_IDLE: begin
        if (start_i) begin
          axis_d  = 2'd0;
          state_d = LEN_DIFF;
        end
      end
      LEN_DIFF: state_d = LEN_MUL;
      LEN_MUL:  state_d = LEN_ACC;
      LEN_ACC: begin
        if (axis_q == 2'd2) begin
          step_d  = 6'(ROOT_W);
          state_d = LEN_ROOT;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = LEN_DIFF;
        end
      end
      LEN_ROOT: begin
        step_d = step_q - 6'd1;
        if (step_q == 6'd1) begin
          done_d  = 1'b1;
          state_d = LEN_IDLE;
        end
      end
      default: state_d = LEN_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LEN_IDLE;
      axis_q  <= '0;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      LEN_IDLE: begin
        acc_q  <= '0;
        rem_q  <= '0;
        root_q <= '0;
      end
      LEN_DIFF: d_q <= diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];
      LEN_MUL:  prod_q <= d_q * d_q;
      LEN_ACC:  acc_q <= acc_q + RAD_W'(prod_q);
      LEN_ROOT: begin
        acc_q  <= {acc_q[RAD_W-3:0], 2'b00};
        rem_q  <= ge ? (rem_n - trial) : rem_n;
        root_q <= {root_q[ROOT_W-2:0], ge};
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign len_o  = root_q;

endmodule

// ===== rtl/core/bspline_knot_vector_builder.sv =====
// Clamped B-spline knot vector builder, chord-length parameters with knot
// averaging. Depends on bkv_pkg, bkv_len and bkv_div.
//
// Points stream in on s_axis, one 96-bit word per point, tlast on the final
// point of a polyline. Each point after the first runs squared deltas for
// the three axes on the one 32x32 multiplier, a two-bit-per-cycle square
// root, and then accept, done and store. The final point starts the compute
// phase, which walks the length memory once; every interior parameter is a
// bit-serial divide with a LEN_W+FRAC_BITS-bit numerator, each of the n+1
// bins takes up to two divides (bin end and bin mean), each interior knot
// one more. The n+p+2 knots (or one fault word: too few points, zero
// length, or a bad n/p pair) leave on m_axis through an output register;
// s_axis is ready only between points. Configuration words on the cfg
// channel are taken at once; write only while the block is idle. Memories
// have no reset and need no clearing pass.
module bspline_knot_vector_builder #(
  parameter int unsigned MAX_POINTS = bkv_pkg::MAX_POINTS_DEF,
  parameter int unsigned MAX_KNOTS  = bkv_pkg::MAX_KNOTS_DEF,
  parameter int unsigned FRAC_BITS  = bkv_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // tdata: coord_x [31:0], coord_y [63:32], coord_z [95:64]
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [95:0]                    s_axis_tdata,
  input  logic                           s_axis_tlast,   // final_point
  // tdata: knot_value [16:0], zero fill [23:17]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [23:0]                    m_axis_tdata,
  output logic                           m_axis_tlast,   // last_knot
  output logic                           m_axis_tuser,   // fault
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bkv_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bkv_pkg::CFG_DAT_W-1:0]  cfg_data_i
);
  import bkv_pkg::*;

  localparam int unsigned AW     = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int unsigned KW     = FRAC_BITS + 1;            // knot incl. 1.0
  localparam int unsigned BW     = $clog2(BIN_DEPTH);
  localparam int unsigned NUM_W  = CNT_W + 7;                // bin end numerator
  localparam int unsigned SUM_W  = CNT_W + KW;
  localparam int unsigned DIVN_W = LEN_W + FRAC_BITS;
  localparam logic [KW-1:0] ONE  = KW'(1) << FRAC_BITS;

  bkv_state_e state_q, state_d;

  // config
  logic [N_W-1:0] ncfg_q;
  logic [P_W-1:0] deg_q;

  // load phase
  point_t            cur_q, cur_d, prev_q, prev_d;
  logic              fin_q, fin_d;
  logic [LEN_W-1:0]  run_q, run_d;
  logic [CNT_W-1:0]  pts_q, pts_d;

  // compute phase
  logic [CNT_W-1:0]  m_q, m_d, low_q, low_d, high_q, high_d, j_q, j_d, cnt_q, cnt_d;
  logic [LEN_W-1:0]  tot_q, tot_d;
  logic [N_W-1:0]    n_q, n_d, i_q, i_d;
  logic [P_W-1:0]    p_q, p_d, t_q, t_d;
  logic [NUM_W-1:0]  num_q, num_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [6:0]        k_q, k_d;
  logic [KW+2:0]     ksum_q, ksum_d;
  logic [KW-1:0]     kval_q, kval_d;
  logic              klast_q, klast_d, kfault_q, kfault_d;

  // output register
  logic              ov_q, ov_d, olast_q, olast_d, ofault_q, ofault_d;
  logic [KW-1:0]     oknot_q, oknot_d;

  // memories
  logic [LEN_W-1:0]  cum_mem [MAX_POINTS];
  logic [KW-1:0]     bin_mem [BIN_DEPTH];
  logic [LEN_W-1:0]  cum_rd_q;
  logic [KW-1:0]     bin_rd_q;
  logic              cum_we, bin_we;
  logic [KW-1:0]     bin_wd;
  logic [6:0]        bin_ra;

  // units
  logic              len_start, len_done;
  logic [ROOT_W-1:0] len_val;
  logic [LEN_W:0]    len_sum;
  logic              div_start, div_done;
  logic [DIVN_W-1:0] div_num, div_quo;
  logic [LEN_W-1:0]  div_den;

  logic [P_W-1:0]    p_eff;
  logic              bad;
  logic [KW+16:0]    oknot_ext;

  bkv_len u_len (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (len_start),
    .cur_i   (cur_q),
    .prev_i  (prev_q),
    .done_o  (len_done),
    .len_o   (len_val)
  );

  bkv_div #(
    .NUM_W (DIVN_W),
    .DEN_W (LEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // configuration, always ready
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncfg_q <= LAST_CTRL_RST;
      deg_q  <= DEGREE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_LAST_CTRL: ncfg_q <= cfg_data_i[N_W-1:0];
        REG_DEGREE:    deg_q  <= cfg_data_i[P_W-1:0];
        default: ;
      endcase
    end
  end

  assign len_sum = {1'b0, run_q} + (LEN_W + 1)'(len_val);
  assign p_eff   = (deg_q == '0) ? P_W'(1) : deg_q;
  // fault check on the raw run totals and the configuration
  assign bad = (32'(pts_q) < 32'd2) || (32'(pts_q) < 32'(ncfg_q) + 32'd1) ||
               (run_q == '0) || (ncfg_q < N_W'(p_eff)) ||
               (32'(ncfg_q) + 32'd1 > 32'(BIN_DEPTH)) ||
               (32'(ncfg_q) + 32'(p_eff) + 32'd2 > 32'(MAX_KNOTS));

  assign s_axis_tready = (state_q == ST_IDLE);
  assign bin_ra = k_q - 7'(p_q) + 7'(t_q);

  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;    prev_d  = prev_q;  fin_d   = fin_q;
    run_d    = run_q;    pts_d   = pts_q;
    m_d      = m_q;      tot_d   = tot_q;   n_d     = n_q;    p_d = p_q;
    i_d      = i_q;      low_d   = low_q;   high_d  = high_q; j_d = j_q;
    num_d    = num_q;    sum_d   = sum_q;   cnt_d   = cnt_q;
    k_d      = k_q;      t_d     = t_q;     ksum_d  = ksum_q;
    kval_d   = kval_q;   klast_d = klast_q; kfault_d = kfault_q;
    ov_d     = ov_q & ~m_axis_tready;
    oknot_d  = oknot_q;  olast_d = olast_q; ofault_d = ofault_q;
    len_start = 1'b0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    cum_we    = 1'b0;
    bin_we    = 1'b0;
    bin_wd    = '0;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cur_d = s_axis_tdata;
          fin_d = s_axis_tlast;
          if (32'(pts_q) < 32'(MAX_POINTS)) begin
            if (pts_q != '0) begin
              len_start = 1'b1;
              state_d   = ST_LEN;
            end else begin
              state_d = ST_STORE;
            end
          end else if (s_axis_tlast) begin
            state_d = ST_CHECK;   // store full: point dropped, run still ends
          end
        end
      end
      ST_LEN: begin
        if (len_done) begin
          run_d   = len_sum[LEN_W] ? '1 : len_sum[LEN_W-1:0];
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        cum_we  = 1'b1;
        prev_d  = cur_q;
        pts_d   = pts_q + CNT_W'(1);
        state_d = fin_q ? ST_CHECK : ST_IDLE;
      end
      ST_CHECK: begin
        m_d    = pts_q;
        tot_d  = run_q;
        n_d    = ncfg_q;
        p_d    = p_eff;
        run_d  = '0;
        pts_d  = '0;
        prev_d = '0;
        if (bad) begin
          kval_d   = '0;
          klast_d  = 1'b1;
          kfault_d = 1'b1;
          state_d  = ST_PUSH;
        end else begin
          klast_d  = 1'b0;
          kfault_d = 1'b0;
          i_d      = '0;
          low_d    = '0;
          num_d    = (NUM_W'(pts_q) << 1) - NUM_W'(ncfg_q) - NUM_W'(1);
          state_d  = ST_BEND;
        end
      end
      // bin end = floor(((i+1)*2m - (n+1)) / (2(n+1)))
      ST_BEND: begin
        div_start = 1'b1;
        div_num   = DIVN_W'(num_q);
        div_den   = LEN_W'({n_q, 1'b0}) + LEN_W'(2);
        state_d   = ST_BEND_W;
      end
      ST_BEND_W: begin
        if (div_done) begin
          high_d  = (div_quo > DIVN_W'(m_q - CNT_W'(1))) ? (m_q - CNT_W'(1))
                                                         : div_quo[CNT_W-1:0];
          j_d     = low_q;
          sum_d   = '0;
          cnt_d   = '0;
          state_d = ST_RD;
        end
      end
      ST_RD: state_d = (j_q > high_q) ? ST_MEAN : ST_U;
      ST_U: begin
        if (j_q == '0 || j_q == m_q - CNT_W'(1) || cum_rd_q >= tot_q) begin
          sum_d   = sum_q + ((j_q == '0) ? SUM_W'(0) : SUM_W'(ONE));
          cnt_d   = cnt_q + CNT_W'(1);
          j_d     = j_q + CNT_W'(1);
          state_d = ST_RD;
        end else begin
          div_start = 1'b1;
          div_num   = {cum_rd_q, FRAC_BITS'(0)};
          div_den   = tot_q;
          state_d   = ST_U_W;
        end
      end
      ST_U_W: begin
        if (div_done) begin
          sum_d   = sum_q + SUM_W'(div_quo[KW-1:0]);
          cnt_d   = cnt_q + CNT_W'(1);
          j_d     = j_q + CNT_W'(1);
          state_d = ST_RD;
        end
      end
      ST_MEAN: begin
        if (cnt_q == '0) begin
          bin_we  = 1'b1;
          state_d = ST_NEXT_BIN;
        end else begin
          div_start = 1'b1;
          div_num   = DIVN_W'(sum_q);
          div_den   = LEN_W'(cnt_q);
          state_d   = ST_MEAN_W;
        end
      end
      ST_MEAN_W: begin
        if (div_done) begin
          bin_we  = 1'b1;
          bin_wd  = div_quo[KW-1:0];
          state_d = ST_NEXT_BIN;
        end
      end
      ST_NEXT_BIN: begin
        low_d = high_q + CNT_W'(1);
        num_d = num_q + (NUM_W'(m_q) << 1);
        if (i_q == n_q) begin
          k_d     = '0;
          state_d = ST_EMIT;
        end else begin
          i_d     = i_q + N_W'(1);
          state_d = ST_BEND;
        end
      end
      ST_EMIT: begin
        if (k_q <= 7'(p_q)) begin
          kval_d  = '0;
          state_d = ST_PUSH;
        end else if (k_q >= 7'(n_q) + 7'd1) begin
          kval_d  = ONE;
          klast_d = (k_q == 7'(n_q) + 7'(p_q) + 7'd1);
          state_d = ST_PUSH;
        end else begin
          t_d     = '0;
          ksum_d  = '0;
          state_d = ST_KRD;
        end
      end
      ST_KRD: state_d = ST_KACC;
      ST_KACC: begin
        ksum_d = ksum_q + (KW + 3)'(bin_rd_q);
        t_d    = t_q + P_W'(1);
        if (t_q + P_W'(1) == p_q) begin
          div_start = 1'b1;
          div_num   = DIVN_W'(ksum_d);
          div_den   = LEN_W'(p_q);
          state_d   = ST_KDIV;
        end else begin
          state_d = ST_KRD;
        end
      end
      ST_KDIV: begin
        if (div_done) begin
          kval_d  = div_quo[KW-1:0];
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!ov_q || m_axis_tready) begin
          ov_d     = 1'b1;
          oknot_d  = kval_q;
          olast_d  = klast_q;
          ofault_d = kfault_q;
          if (klast_q) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + 7'd1;
            state_d = ST_EMIT;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      prev_q  <= '0;
      run_q   <= '0;
      pts_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      prev_q  <= prev_d;
      run_q   <= run_d;
      pts_q   <= pts_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;   fin_q   <= fin_d;
    m_q     <= m_d;     tot_q   <= tot_d;   n_q    <= n_d;    p_q  <= p_d;
    i_q     <= i_d;     low_q   <= low_d;   high_q <= high_d; j_q  <= j_d;
    num_q   <= num_d;   sum_q   <= sum_d;   cnt_q  <= cnt_d;
    k_q     <= k_d;     t_q     <= t_d;     ksum_q <= ksum_d;
    kval_q  <= kval_d;  klast_q <= klast_d; kfault_q <= kfault_d;
    oknot_q <= oknot_d; olast_q <= olast_d; ofault_q <= ofault_d;
  end

  // running length store, one write per point, one read per parameter
  always_ff @(posedge clk_i) begin
    if (cum_we) begin
      cum_mem[pts_q[AW-1:0]] <= run_q;
    end
    if (state_q == ST_RD) begin
      cum_rd_q <= cum_mem[j_q[AW-1:0]];
    end
  end

  // bin averages
  always_ff @(posedge clk_i) begin
    if (bin_we) begin
      bin_mem[i_q[BW-1:0]] <= bin_wd;
    end
    if (state_q == ST_KRD) begin
      bin_rd_q <= bin_mem[bin_ra[BW-1:0]];
    end
  end

  assign oknot_ext     = {17'b0, oknot_q};
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {7'b0, oknot_ext[KNOT_W-1:0]};
  assign m_axis_tlast  = olast_q;
  assign m_axis_tuser  = ofault_q;

endmodule
